[sv/alc_pkg.sv]
package alc_pkg;

    localparam int LINE_COUNT   = 5;
    localparam int LINE_WORDS   = 10;
    localparam int MEMORY_WORDS = 100;
    localparam int MISS_TICKS   = 10;

    localparam int LINE_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int OFFS_W = $clog2(LINE_WORDS);
    localparam int TAG_W  = 4;
    localparam int ADDR_W = 7;
    localparam int MEMA_W = $clog2(MEMORY_WORDS);
    localparam int CACHE_DEPTH = LINE_COUNT * LINE_WORDS;
    localparam int CACHE_W = $clog2(CACHE_DEPTH);

    // tag = (address * TAG_RECIP) >> TAG_SHIFT, exact for every 7-bit address
    localparam int TAG_RECIP = 205;
    localparam int TAG_SHIFT = 11;
    localparam int TAG_PROD_W = 15;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_ADDR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_VALUE = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic CFG_VALUE_MIN = 1'b0;
    localparam logic CFG_VALUE_MAX = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOOKUP,
        ST_VICTIM,
        ST_WB_RD,
        ST_WB_WR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_ACCESS,
        ST_ACCESS_WR,
        ST_DONE
    } state_t;

endpackage

[sv/assoc_lru_word_cache_core.sv]
// channel  | valid  | stall  | payload
// in       | valid  | stall  | op, address, write_value
// out      | out_valid | out_stall | read_data, hit, status, miss_penalty
// cfg      | cfg_we | -      | cfg_index, cfg_data
// A hit passes CHECK, LOOKUP, VICTIM, ACCESS, ACCESS_WR and DONE on its way to the
// result register; a miss scans the lines in VICTIM, checks the dirty mark in WB_RD,
// and takes a read state and a write state per word of write-back and of fill, set
// by the single cache and memory ports. Rejected accesses go from CHECK to DONE.
// Reset clears line state and the stamp counter; memory reads as zero through
// a written mask. No new word is taken while a result waits under stall.
module assoc_lru_word_cache_core
    import alc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        valid,
    output logic        stall,
    input  logic        op,
    input  logic [6:0]  address,
    input  logic [15:0] write_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic        hit,
    output logic [1:0]  status,
    output logic [3:0]  miss_penalty
);

    state_t state_reg, state_next;

    logic [15:0] vmin_reg, vmax_reg;
    logic        op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [15:0] wv_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [OFFS_W-1:0] offs_reg;

    logic [LINE_COUNT-1:0] valid_reg, dirty_reg;
    logic [TAG_W-1:0]  tags_reg  [LINE_COUNT];
    logic [31:0]       stamp_reg [LINE_COUNT];
    logic [31:0]       counter_reg;

    logic [LINE_W-1:0] idx_reg;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] best_reg;
    logic              found_inv_reg;
    logic              hit_reg;
    logic [OFFS_W-1:0] word_reg;

    logic [15:0] cache_mem [CACHE_DEPTH];
    logic [15:0] back_mem  [MEMORY_WORDS];
    logic [MEMORY_WORDS-1:0] written_reg;
    logic [15:0] cache_q, back_q;

    logic [15:0] rd_reg;
    logic        ohit_reg;
    logic [1:0]  status_reg;
    logic [3:0]  pen_reg;
    logic        ovalid_reg;

    // cache / memory port controls
    logic              c_we, c_re, b_we, b_re;
    logic [CACHE_W-1:0] c_addr;
    logic [15:0]       c_wdata, b_wdata;
    logic [MEMA_W-1:0] b_addr;
    logic [ADDR_W+1:0] wb_a, fill_a;

    // address split by reciprocal multiply
    logic [TAG_PROD_W-1:0] tag_prod;
    logic [TAG_W-1:0]      tag_in;
    logic [ADDR_W-1:0]     line_base;

    assign stall = (state_reg != ST_IDLE) || ovalid_reg;
    assign out_valid = ovalid_reg;
    assign read_data = rd_reg;
    assign hit = ohit_reg;
    assign status = status_reg;
    assign miss_penalty = pen_reg;

    assign tag_prod  = TAG_PROD_W'(address) * TAG_PROD_W'(TAG_RECIP);
    assign tag_in    = TAG_W'(tag_prod >> TAG_SHIFT);
    assign line_base = ADDR_W'(tag_in) * ADDR_W'(LINE_WORDS);

    assign wb_a   = (ADDR_W+2)'(tags_reg[line_reg] * LINE_WORDS) + (ADDR_W+2)'(word_reg);
    assign fill_a = (ADDR_W+2)'(tag_reg * LINE_WORDS) + (ADDR_W+2)'(word_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmin_reg <= 16'd0;
            vmax_reg <= 16'd32767;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_VALUE_MIN)
                vmin_reg <= cfg_data;
            else
                vmax_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (valid && !ovalid_reg) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (addr_reg >= ADDR_W'(MEMORY_WORDS))
                    state_next = ST_DONE;
                else if (op_reg == OP_WRITE && (wv_reg < vmin_reg || wv_reg > vmax_reg))
                    state_next = ST_DONE;
                else
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:    state_next = ST_VICTIM;
            ST_VICTIM:
            begin
                if (hit_reg)
                    state_next = ST_ACCESS;
                else if (idx_reg == LINE_W'(LINE_COUNT - 1) || found_inv_reg)
                    state_next = ST_WB_RD;
            end
            ST_WB_RD:
            begin
                if (!(valid_reg[line_reg] && dirty_reg[line_reg]))
                    state_next = ST_FILL_RD;
                else
                    state_next = ST_WB_WR;
            end
            ST_WB_WR:
                state_next = (word_reg == OFFS_W'(LINE_WORDS - 1)) ? ST_FILL_RD : ST_WB_RD;
            ST_FILL_RD:   state_next = ST_FILL_WR;
            ST_FILL_WR:
                state_next = (word_reg == OFFS_W'(LINE_WORDS - 1)) ? ST_ACCESS : ST_FILL_RD;
            ST_ACCESS:    state_next = ST_ACCESS_WR;
            ST_ACCESS_WR: state_next = ST_DONE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // port drive
    always_comb
    begin
        c_we = 1'b0; c_re = 1'b0; b_we = 1'b0; b_re = 1'b0;
        c_addr = '0; c_wdata = wv_reg; b_addr = '0; b_wdata = wv_reg;
        unique case (state_reg)
            ST_WB_RD:
            begin
                c_re = 1'b1;
                c_addr = CACHE_W'(line_reg * LINE_WORDS) + CACHE_W'(word_reg);
            end
            ST_WB_WR:
            begin
                b_we = (wb_a < (ADDR_W+2)'(MEMORY_WORDS));
                b_addr = MEMA_W'(wb_a);
                b_wdata = cache_q;
            end
            ST_FILL_RD:
            begin
                b_re = 1'b1;
                b_addr = MEMA_W'(fill_a);
            end
            ST_FILL_WR:
            begin
                c_we = 1'b1;
                c_addr = CACHE_W'(line_reg * LINE_WORDS) + CACHE_W'(word_reg);
                c_wdata = (fill_a < (ADDR_W+2)'(MEMORY_WORDS) &&
                           written_reg[MEMA_W'(fill_a)]) ? back_q : 16'd0;
            end
            ST_ACCESS:
            begin
                c_addr = CACHE_W'(line_reg * LINE_WORDS) + CACHE_W'(offs_reg);
                c_re = (op_reg == OP_READ);
                c_we = (op_reg == OP_WRITE);
                b_we = (op_reg == OP_WRITE);
                b_addr = MEMA_W'(addr_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            cache_mem[c_addr] <= c_wdata;
        if (c_re)
            cache_q <= cache_mem[c_addr];
        if (b_we)
            back_mem[b_addr] <= b_wdata;
        if (b_re)
            back_q <= back_mem[b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            op_reg <= op;
            addr_reg <= address;
            wv_reg <= write_value;
            tag_reg <= tag_in;
            offs_reg <= OFFS_W'(address - line_base);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            counter_reg <= 32'd0;
            written_reg <= '0;
            ovalid_reg <= 1'b0;
            idx_reg <= '0;
            line_reg <= '0;
            best_reg <= '0;
            found_inv_reg <= 1'b0;
            hit_reg <= 1'b0;
            word_reg <= '0;
            rd_reg <= '0;
            ohit_reg <= 1'b0;
            status_reg <= STATUS_OK;
            pen_reg <= '0;
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                stamp_reg[i] <= 32'd0;
                tags_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (b_we)
                written_reg[b_addr] <= 1'b1;
            unique case (state_reg)
                ST_LOOKUP:
                begin
                    // parallel tag compare
                    hit_reg <= 1'b0;
                    for (int i = LINE_COUNT - 1; i >= 0; i--)
                        if (valid_reg[i] && tags_reg[i] == tag_reg)
                        begin
                            hit_reg <= 1'b1;
                            line_reg <= LINE_W'(i);
                        end
                    idx_reg <= '0;
                    best_reg <= '0;
                    found_inv_reg <= 1'b0;
                    word_reg <= '0;
                end
                ST_VICTIM:
                begin
                    // the first invalid line ends the scan
                    if (!hit_reg && !found_inv_reg)
                    begin
                        if (!valid_reg[idx_reg])
                        begin
                            found_inv_reg <= 1'b1;
                            line_reg <= idx_reg;
                        end
                        else
                        begin
                            if (stamp_reg[idx_reg] < stamp_reg[best_reg])
                            begin
                                best_reg <= idx_reg;
                                line_reg <= idx_reg;
                            end
                            else
                                line_reg <= best_reg;
                        end
                        if (idx_reg != LINE_W'(LINE_COUNT - 1))
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_WB_RD: ;
                ST_WB_WR:
                    word_reg <= (word_reg == OFFS_W'(LINE_WORDS - 1)) ? '0 : word_reg + 1'b1;
                ST_FILL_WR:
                begin
                    if (word_reg == OFFS_W'(LINE_WORDS - 1))
                    begin
                        word_reg <= '0;
                        tags_reg[line_reg] <= tag_reg;
                        valid_reg[line_reg] <= 1'b1;
                        dirty_reg[line_reg] <= 1'b0;
                        counter_reg <= counter_reg + 32'd1;
                    end
                    else
                        word_reg <= word_reg + 1'b1;
                end
                ST_ACCESS:
                begin
                    if (op_reg == OP_WRITE)
                        dirty_reg[line_reg] <= 1'b1;
                    stamp_reg[line_reg] <= counter_reg + 32'd1;
                    counter_reg <= counter_reg + 32'd1;
                end
                ST_DONE:
                begin
                    ovalid_reg <= 1'b1;
                    if (addr_reg >= ADDR_W'(MEMORY_WORDS))
                    begin
                        status_reg <= STATUS_BAD_ADDR;
                        rd_reg <= '0; ohit_reg <= 1'b0; pen_reg <= '0;
                    end
                    else if (op_reg == OP_WRITE && (wv_reg < vmin_reg || wv_reg > vmax_reg))
                    begin
                        status_reg <= STATUS_BAD_VALUE;
                        rd_reg <= '0; ohit_reg <= 1'b0; pen_reg <= '0;
                    end
                    else
                    begin
                        status_reg <= STATUS_OK;
                        rd_reg <= (op_reg == OP_READ) ? cache_q : 16'd0;
                        ohit_reg <= hit_reg;
                        pen_reg <= hit_reg ? 4'd0 : 4'(MISS_TICKS);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[sv/alc_checker.sv]
module alc_checker
    import alc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       hit,
    input logic [1:0] status,
    input logic [3:0] miss_penalty,
    input logic [15:0] read_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data))
        else $error("result dropped under stall");

    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stall)
        else $error("word taken with result pending");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> !hit && miss_penalty == 4'd0
            && read_data == 16'd0)
        else $error("error result carries data");

    a_penalty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK |-> (hit == (miss_penalty == 4'd0)))
        else $error("penalty inconsistent with hit");

endmodule

bind assoc_lru_word_cache_core alc_checker u_alc_checker (
    .clk(clk), .rst_n(rst_n), .stall(stall),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
    .status(status), .miss_penalty(miss_penalty), .read_data(read_data)
);
